// File: rtl/atps_pkg.sv
// Package: shared types, codes and constants of the ATA PIO transfer sequencer
package atps_pkg;

  localparam int WORDS_PER_SECTOR = 256;
  localparam int WIDX_W = 9;

  localparam logic [1:0] MODE_REQ    = 2'd0;
  localparam logic [1:0] MODE_STATUS = 2'd1;
  localparam logic [1:0] MODE_RDATA  = 2'd2;
  localparam logic [1:0] MODE_WDATA  = 2'd3;

  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_GWRITE  = 2'd1;
  localparam logic [1:0] OP_RWRITE  = 2'd2;
  localparam logic [1:0] OP_BAD     = 2'd3;

  localparam logic [2:0] K_REGWR  = 3'd0;
  localparam logic [2:0] K_STATRD = 3'd1;
  localparam logic [2:0] K_DATARD = 3'd2;
  localparam logic [2:0] K_WORD   = 3'd3;
  localparam logic [2:0] K_NEEDWR = 3'd4;
  localparam logic [2:0] K_DONE   = 3'd5;

  localparam logic [1:0] CFG_PRESENT  = 2'd0;
  localparam logic [1:0] CFG_RESERVED = 2'd1;
  localparam logic [1:0] CFG_POLL     = 2'd2;

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_WAIT_READY = 4'd1;
  localparam logic [3:0] PH_WAIT_DRQ   = 4'd2;
  localparam logic [3:0] PH_READ       = 4'd3;
  localparam logic [3:0] PH_WRITE      = 4'd4;
  localparam logic [3:0] PH_WAIT_FLUSH = 4'd5;

  localparam logic [7:0] ST_ERR = 8'h01;
  localparam logic [7:0] ST_DRQ = 8'h08;
  localparam logic [7:0] ST_BSY = 8'h80;
  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_FLUSH = 8'hE7;
  localparam logic [7:0] DH_MASTER = 8'hE0;
  localparam logic [7:0] DH_SLAVE  = 8'hF0;

  // Job codes from front to back
  localparam logic [2:0] J_DONE   = 3'd0;  // done with fail flag
  localparam logic [2:0] J_SINGLE = 3'd1;  // one result, kind given
  localparam logic [2:0] J_TASK   = 3'd2;  // six register writes then status read
  localparam logic [2:0] J_PAIR   = 3'd3;  // word/write then second result
  localparam logic [2:0] J_FLUSH  = 3'd4;  // data write, flush, status read

  typedef struct packed {
    logic [2:0]  job;
    logic [15:0] value;    // first word where used
    logic [2:0]  kind2;    // second kind for pair
    logic        fail;
    logic        drive;
    logic        is_read;
    logic [27:0] lba;
    logic [7:0]  count;
  } job_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  reg_addr;
    logic [15:0] value;
    logic        failed;
    logic        last;
  } res_t;

endpackage

// File: rtl/atps_front.sv
// Front part: accepts items, tracks the phase and classifies each expected item into a job
module atps_front
  import atps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [27:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_op,
  input  logic        in_drive,
  input  logic [27:0] in_lba,
  input  logic [7:0]  in_count,
  input  logic [15:0] in_data,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  logic [1:0]        present_r;
  logic [27:0]       reserved_r;
  logic [23:0]       limit_r;
  logic [3:0]        phase_r, phase_nxt;
  logic [23:0]       poll_r, poll_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;
  logic [7:0]        left_r, left_nxt;
  logic [1:0]        op_r, op_nxt;
  logic              drive_r, drive_nxt;
  logic [27:0]       lba_r, lba_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic              emit;
  logic [7:0]        st;
  logic [23:0]       poll_inc;
  logic [WIDX_W-1:0] widx_inc;
  logic [7:0]        left_dec;
  logic              acc;

  assign in_full  = !job_ready;
  assign acc      = in_push && job_ready;
  assign job_valid = acc && emit;
  assign st       = in_data[7:0];
  assign poll_inc = poll_r + 24'd1;
  assign widx_inc = widx_r + 1'b1;
  assign left_dec = left_r - 8'd1;

  // Decode the item against the current phase
  always_comb begin
    phase_nxt = phase_r;
    poll_nxt  = poll_r;
    widx_nxt  = widx_r;
    left_nxt  = left_r;
    op_nxt    = op_r;
    drive_nxt = drive_r;
    lba_nxt   = lba_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    job       = '0;
    job.drive   = drive_r;
    job.is_read = (op_r == OP_READ);
    job.lba     = lba_r;
    job.count   = cnt_r;
    unique case (in_mode)
      MODE_REQ: begin
        if (phase_r == PH_IDLE) begin
          emit = 1'b1;
          op_nxt = in_op; drive_nxt = in_drive; lba_nxt = in_lba; cnt_nxt = in_count;
          if (in_op == OP_BAD || !present_r[in_drive]) begin
            job.job = J_DONE; job.fail = 1'b1;
          end else if (in_count == 8'd0) begin
            job.job = J_DONE;
          end else if (in_op == OP_GWRITE && in_lba < reserved_r) begin
            job.job = J_DONE; job.fail = 1'b1;
          end else begin
            job.job = J_SINGLE; job.kind2 = K_STATRD;
            left_nxt = in_count; poll_nxt = '0; phase_nxt = PH_WAIT_READY;
          end
        end
      end
      MODE_STATUS: begin
        if (phase_r == PH_WAIT_READY || phase_r == PH_WAIT_DRQ ||
            phase_r == PH_WAIT_FLUSH) begin
          emit = 1'b1;
          priority if (phase_r == PH_WAIT_DRQ && (st & ST_ERR) != 8'd0) begin
            job.job = J_DONE; job.fail = 1'b1; phase_nxt = PH_IDLE;
          end else if (phase_r == PH_WAIT_READY && (st & ST_BSY) == 8'd0) begin
            job.job = J_TASK; poll_nxt = '0; phase_nxt = PH_WAIT_DRQ;
          end else if (phase_r == PH_WAIT_DRQ && (st & ST_BSY) == 8'd0 &&
                       (st & ST_DRQ) != 8'd0) begin
            widx_nxt = '0;
            job.job = J_SINGLE;
            job.kind2 = (op_r == OP_READ) ? K_DATARD : K_NEEDWR;
            phase_nxt = (op_r == OP_READ) ? PH_READ : PH_WRITE;
          end else if (phase_r == PH_WAIT_FLUSH && (st & ST_BSY) == 8'd0) begin
            left_nxt = left_dec;
            if (left_dec == 8'd0) begin
              job.job = J_DONE; phase_nxt = PH_IDLE;
            end else begin
              job.job = J_SINGLE; job.kind2 = K_STATRD;
              poll_nxt = '0; phase_nxt = PH_WAIT_DRQ;
            end
          end else begin
            poll_nxt = poll_inc;
            if (poll_inc >= limit_r) begin
              job.job = J_DONE; job.fail = 1'b1; phase_nxt = PH_IDLE;
            end else begin
              job.job = J_SINGLE; job.kind2 = K_STATRD;
            end
          end
        end
      end
      MODE_RDATA: begin
        if (phase_r == PH_READ) begin
          emit = 1'b1;
          widx_nxt = widx_inc;
          job.job = J_PAIR; job.value = in_data;
          if ({1'b0, widx_inc} < (WIDX_W+1)'(WORDS_PER_SECTOR)) begin
            job.kind2 = K_DATARD;
          end else begin
            left_nxt = left_dec;
            if (left_dec == 8'd0) begin
              job.kind2 = K_DONE; phase_nxt = PH_IDLE;
            end else begin
              job.kind2 = K_STATRD; poll_nxt = '0; phase_nxt = PH_WAIT_DRQ;
            end
          end
        end
      end
      MODE_WDATA: begin
        if (phase_r == PH_WRITE) begin
          emit = 1'b1;
          widx_nxt = widx_inc;
          job.value = in_data;
          if ({1'b0, widx_inc} < (WIDX_W+1)'(WORDS_PER_SECTOR)) begin
            job.job = J_PAIR; job.kind2 = K_NEEDWR;
          end else begin
            job.job = J_FLUSH; poll_nxt = '0; phase_nxt = PH_WAIT_FLUSH;
          end
        end
      end
      default: ;
    endcase
  end

  // Hold configuration and sequencing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= 2'd0;
      reserved_r <= 28'd1024;
      limit_r    <= 24'h100000;
      phase_r    <= PH_IDLE;
      poll_r     <= '0;
      widx_r     <= '0;
      left_r     <= '0;
      op_r       <= '0;
      drive_r    <= 1'b0;
      lba_r      <= '0;
      cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_PRESENT:  present_r  <= cfg_data[1:0];
          CFG_RESERVED: reserved_r <= cfg_data;
          CFG_POLL:     limit_r    <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (acc) begin
        phase_r <= phase_nxt; poll_r <= poll_nxt; widx_r <= widx_nxt;
        left_r <= left_nxt; op_r <= op_nxt; drive_r <= drive_nxt;
        lba_r <= lba_nxt; cnt_r <= cnt_nxt;
      end
    end
  end

  // A request accepted during the read phase produces no job
  a_idle_no_job: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ && in_push && !in_full && in_mode == MODE_REQ) |-> !job_valid)
    else $error("request accepted mid-transfer");
  a_widx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, widx_r} <= (WIDX_W+1)'(WORDS_PER_SECTOR)))
    else $error("word index out of range");
  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job.job == J_DONE) |=> (phase_r == PH_IDLE))
    else $error("done without returning to idle");

endmodule

// File: rtl/atps_queue.sv
// Job queue between front and back parts
module atps_queue
  import atps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  localparam int DEPTH = 4;
  job_t       mem [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 3'(DEPTH));
  assign rd_valid = (cnt_r != 3'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_job = mem[rp_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wr_job;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'(DEPTH))
    else $error("queue overflow");
  a_track: assert property (@(posedge clk) disable iff (!rst_n)
    (wr && !rd) |=> (cnt_r == $past(cnt_r) + 3'd1))
    else $error("queue count slip");
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 3'd0) |-> !rd)
    else $error("read from empty queue");

endmodule

// File: rtl/atps_back.sv
// Back part: expands each job into result items and holds them in an output register
module atps_back
  import atps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  job_t        job,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_reg_addr,
  output logic [15:0] out_value,
  output logic        out_failed,
  output logic        out_last
);

  res_t       res_r, r;
  logic       val_r;
  logic [2:0] step_r;
  logic [2:0] nsteps;
  logic       load;
  logic       islast;

  // Number of results for the job at the head
  always_comb begin
    unique case (job.job)
      J_TASK:  nsteps = 3'd7;
      J_PAIR:  nsteps = 3'd2;
      J_FLUSH: nsteps = 3'd3;
      default: nsteps = 3'd1;
    endcase
  end

  // Build the result item for the current step
  always_comb begin
    r = '0;
    islast = (step_r == nsteps - 3'd1);
    r.last = islast;
    unique case (job.job)
      J_DONE: begin r.kind = K_DONE; r.failed = job.fail; end
      J_SINGLE: r.kind = job.kind2;
      J_PAIR: begin
        if (step_r == 3'd0) begin
          r.kind  = (job.kind2 == K_NEEDWR) ? K_REGWR : K_WORD;
          r.value = job.value;
        end else begin
          r.kind = job.kind2;
        end
      end
      J_FLUSH: begin
        unique case (step_r)
          3'd0:    begin r.kind = K_REGWR; r.value = job.value; end
          3'd1:    begin r.kind = K_REGWR; r.reg_addr = 3'd7;
                         r.value = {8'd0, CMD_FLUSH}; end
          default: r.kind = K_STATRD;
        endcase
      end
      J_TASK: begin
        r.kind = K_REGWR;
        unique case (step_r)
          3'd0: begin r.reg_addr = 3'd6; r.value = {8'd0,
                  (job.drive ? DH_SLAVE : DH_MASTER) | {4'd0, job.lba[27:24]}}; end
          3'd1: begin r.reg_addr = 3'd2; r.value = {8'd0, job.count}; end
          3'd2: begin r.reg_addr = 3'd3; r.value = {8'd0, job.lba[7:0]}; end
          3'd3: begin r.reg_addr = 3'd4; r.value = {8'd0, job.lba[15:8]}; end
          3'd4: begin r.reg_addr = 3'd5; r.value = {8'd0, job.lba[23:16]}; end
          3'd5: begin r.reg_addr = 3'd7;
                  r.value = {8'd0, job.is_read ? CMD_READ : CMD_WRITE}; end
          default: r.kind = K_STATRD;
        endcase
      end
      default: ;
    endcase
  end

  assign load      = job_valid && (!val_r || out_pop);
  assign job_ready = load && islast;
  assign out_empty = !val_r;
  assign out_kind = res_r.kind;
  assign out_reg_addr = res_r.reg_addr;
  assign out_value = res_r.value;
  assign out_failed = res_r.failed;
  assign out_last = res_r.last;

  // Advance the step counter and refill the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= 1'b0; step_r <= '0;
    end else begin
      if (load) begin
        val_r <= 1'b1;
        step_r <= islast ? 3'd0 : step_r + 3'd1;
      end else if (out_pop) begin
        val_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= r;
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (val_r && !out_pop) |=> (val_r && $stable(res_r)))
    else $error("result dropped under stall");
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (val_r && res_r.kind == K_DONE) |-> res_r.last)
    else $error("done not last");
  a_step: assert property (@(posedge clk) disable iff (!rst_n) step_r < 3'd7)
    else $error("step overrun");

endmodule

// File: rtl/ata_pio_transfer_sequencer_top.sv
// Top level: ATA PIO LBA28 host sequencer
// Usage:
//   Input channel (in_push/in_full) takes requests, device status bytes, device
//   data words and host write words, selected by in_mode. Items that the current
//   phase does not expect are accepted and dropped with no result.
//   Result channel (out_empty/out_pop) delivers register writes, status and data
//   read requests, delivered words, write-word requests and a done marker;
//   out_last flags the final result of each input item.
//   Configuration (cfg_we/cfg_index/cfg_data) writes present mask, reserved LBA
//   and poll limit; write only while idle.
// Timing:
//   The front decodes an item in the cycle it is accepted and pushes at most one job
//   into a four-entry queue. The back emits one result per cycle into an output
//   register while the receiver pops, so the first result reaches the out ports
//   through the queue and then the output register. An item causes as many results
//   as it needs: one or two for polls and data words, three per flush, seven for the
//   task file setup. A stalled receiver fills the output register, then the queue,
//   then in_full rises. Synchronous reset empties both and returns to idle with the
//   register reset values.
module ata_pio_transfer_sequencer_top
  import atps_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [27:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_mode,
  input  logic [1:0]  in_op,
  input  logic        in_drive,
  input  logic [27:0] in_lba,
  input  logic [7:0]  in_count,
  input  logic [15:0] in_data,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_reg_addr,
  output logic [15:0] out_value,
  output logic        out_failed,
  output logic        out_last
);

  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  atps_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_push, .in_full, .in_mode, .in_op, .in_drive, .in_lba, .in_count, .in_data,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  atps_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_job(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_job(bj)
  );

  atps_back u_back (
    .clk, .rst_n, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_empty, .out_pop, .out_kind, .out_reg_addr, .out_value, .out_failed, .out_last
  );

endmodule
